// ===== hdl/skct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sparse key count table.
package skct_pkg;

	localparam int KEY_W = 31;
	localparam int CNT_W = 32;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Operation codes; the unused code behaves as a query.
	localparam logic [KIND_W-1:0] KIND_INC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEC = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QRY = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// Operation token that walks down the row of cells.
	typedef struct packed {
		logic                valid;
		logic [KIND_W-1:0]   kind;
		logic [KEY_W-1:0]    key;
		logic                found;
		logic                bumped;
		logic [CNT_W-1:0]    cnt;
		logic                free_found;
	} tok_t;

endpackage

// ===== hdl/skct_cell.sv =====
`timescale 1ns / 1ps
// One slot of the table: key, count and valid bit, plus a token register.
module skct_cell #(
	parameter int IDX = 0,
	parameter int IDX_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  skct_pkg::tok_t            tok_in,
	input  logic [IDX_W-1:0]          free_idx_in,
	input  logic                      alloc_en,
	input  logic [IDX_W-1:0]          alloc_idx,
	input  logic [skct_pkg::KEY_W-1:0] alloc_key,
	output skct_pkg::tok_t            tok_out,
	output logic [IDX_W-1:0]          free_idx_out
);

	logic [skct_pkg::KEY_W-1:0] key_q;
	logic [skct_pkg::CNT_W-1:0] count_q;
	logic                       valid_q;

	skct_pkg::tok_t             tok_q;
	logic [IDX_W-1:0]           free_idx_q;

	skct_pkg::tok_t             tok_nxt;
	logic [IDX_W-1:0]           free_idx_nxt;
	logic [skct_pkg::CNT_W-1:0] count_nxt;
	logic                       valid_nxt;
	logic                       match;
	logic                       take_free;
	logic                       alloc_here;

	assign match = tok_in.valid && valid_q && !tok_in.found && (key_q == tok_in.key);
	assign take_free = tok_in.valid && !valid_q && !tok_in.free_found;
	assign alloc_here = alloc_en && (alloc_idx == IDX_W'(IDX));

	always_comb begin
		tok_nxt = tok_in;
		free_idx_nxt = free_idx_in;
		count_nxt = count_q;
		valid_nxt = valid_q;
		if (match) begin
			tok_nxt.found = 1'b1;
			case (tok_in.kind)
				skct_pkg::KIND_INC: begin
					if (count_q != skct_pkg::CNT_MAX) begin
						count_nxt = count_q + 1'b1;
						tok_nxt.bumped = 1'b1;
					end
					tok_nxt.cnt = count_nxt;
				end
				skct_pkg::KIND_DEC: begin
					// A count of one or less empties the slot.
					if (count_q[skct_pkg::CNT_W-1:1] == '0) begin
						count_nxt = '0;
						valid_nxt = 1'b0;
					end else begin
						count_nxt = count_q - 1'b1;
					end
					tok_nxt.cnt = count_nxt;
				end
				default: begin
					tok_nxt.cnt = count_q;
				end
			endcase
		end
		if (take_free) begin
			tok_nxt.free_found = 1'b1;
			free_idx_nxt = IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q <= '0;
		end else begin
			valid_q <= alloc_here ? 1'b1 : valid_nxt;
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_here) begin
			key_q <= alloc_key;
			count_q <= skct_pkg::CNT_W'(1);
		end else begin
			count_q <= count_nxt;
		end
		free_idx_q <= free_idx_nxt;
	end

	assign tok_out = tok_q;
	assign free_idx_out = free_idx_q;

endmodule

// ===== hdl/sparse_key_count_table.sv =====
`timescale 1ns / 1ps
// Top level of the sparse key count table: a row of slot cells and its control.
// A request token passes through the token register of every cell, then the output register.
// A new request is taken only once the previous token has left the cell row.
// A request can be taken while a result waits at the output, but not while one is parked.
// Reset clears all slot valid bits, the running total and the handshake state at once;
// slot keys and counts are left as they are and are never read before being written.
module sparse_key_count_table #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [skct_pkg::KIND_W-1:0]    kind,
	input  logic [skct_pkg::KEY_W-1:0]     key,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [skct_pkg::CNT_W-1:0]     key_count,
	output logic [skct_pkg::CNT_W-1:0]     total_count,
	output logic [skct_pkg::STATUS_W-1:0]  status
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// The token chain: entry 0 is the request, entry CAPACITY leaves the last cell.
	skct_pkg::tok_t   tok [0:CAPACITY];
	logic [IDX_W-1:0] free_idx [0:CAPACITY];

	logic busy_q;
	logic park_valid_q;
	logic rsp_valid_q;
	logic [skct_pkg::CNT_W-1:0] total_q;

	logic [skct_pkg::CNT_W-1:0]    key_count_q;
	logic [skct_pkg::CNT_W-1:0]    total_count_q;
	logic [skct_pkg::STATUS_W-1:0] status_q;
	logic [skct_pkg::CNT_W-1:0]    park_count_q;
	logic [skct_pkg::CNT_W-1:0]    park_total_q;
	logic [skct_pkg::STATUS_W-1:0] park_status_q;

	logic accept;
	logic fin;
	logic take;
	logic out_free;

	// Result of the finishing token and the allocation it may cause.
	logic [skct_pkg::CNT_W-1:0]    fin_count;
	logic [skct_pkg::CNT_W-1:0]    total_nxt;
	logic [skct_pkg::STATUS_W-1:0] fin_status;
	logic                          alloc_en;

	assign accept = req_valid && !req_stall;
	assign req_stall = busy_q || park_valid_q;
	assign fin = tok[CAPACITY].valid;
	assign take = rsp_valid_q && !rsp_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// A new token is presented to the first cell in the same cycle as its transfer.
	always_comb begin
		tok[0].valid = accept;
		tok[0].kind = kind;
		tok[0].key = key;
		tok[0].found = 1'b0;
		tok[0].bumped = 1'b0;
		tok[0].cnt = '0;
		tok[0].free_found = 1'b0;
		free_idx[0] = '0;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skct_cell #(
			.IDX   (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.tok_in       (tok[i]),
			.free_idx_in  (free_idx[i]),
			.alloc_en     (alloc_en),
			.alloc_idx    (free_idx[CAPACITY]),
			.alloc_key    (tok[CAPACITY].key),
			.tok_out      (tok[i+1]),
			.free_idx_out (free_idx[i+1])
		);
	end

	// When the token leaves the row, the matched slot (if any) has already been
	// updated. What is left is the running total, the status and, for an
	// increment of an absent key, writing the lowest free slot found on the way.
	always_comb begin
		fin_count = tok[CAPACITY].cnt;
		fin_status = skct_pkg::STATUS_OK;
		total_nxt = total_q;
		alloc_en = 1'b0;
		case (tok[CAPACITY].kind)
			skct_pkg::KIND_INC: begin
				if (tok[CAPACITY].found) begin
					if (tok[CAPACITY].bumped && total_q != skct_pkg::CNT_MAX) begin
						total_nxt = total_q + 1'b1;
					end
				end else if (tok[CAPACITY].free_found) begin
					alloc_en = fin;
					fin_count = skct_pkg::CNT_W'(1);
					if (total_q != skct_pkg::CNT_MAX) begin
						total_nxt = total_q + 1'b1;
					end
				end else begin
					fin_status = skct_pkg::STATUS_FULL;
					fin_count = '0;
				end
			end
			skct_pkg::KIND_DEC: begin
				if (tok[CAPACITY].found) begin
					if (total_q != '0) begin
						total_nxt = total_q - 1'b1;
					end
				end else begin
					fin_status = skct_pkg::STATUS_ABSENT;
					fin_count = '0;
				end
			end
			default: begin
				// Queries, including the unused code, change nothing.
				fin_count = tok[CAPACITY].cnt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			park_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (fin) begin
				total_q <= total_nxt;
				if (out_free) begin
					rsp_valid_q <= 1'b1;
				end else begin
					park_valid_q <= 1'b1;
				end
			end else if (take) begin
				if (park_valid_q) begin
					park_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= 1'b0;
				end
			end
		end
	end

	// Output register and the parking register behind it.
	always_ff @(posedge clk) begin
		if (fin) begin
			if (out_free) begin
				key_count_q <= fin_count;
				total_count_q <= total_nxt;
				status_q <= fin_status;
			end else begin
				park_count_q <= fin_count;
				park_total_q <= total_nxt;
				park_status_q <= fin_status;
			end
		end else if (take && park_valid_q) begin
			key_count_q <= park_count_q;
			total_count_q <= park_total_q;
			status_q <= park_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign key_count = key_count_q;
	assign total_count = total_count_q;
	assign status = status_q;

endmodule

// ===== bench/tb_sparse_key_count_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sparse key count table: directed, fill, random and hold tests.
module tb_sparse_key_count_table;

	localparam int CAPACITY = 64;
	// Code 3 is not an operation; the table treats it as a query.
	localparam logic [skct_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [skct_pkg::KEY_W-1:0] KEY_TOP = {skct_pkg::KEY_W{1'b1}};
	// Number of distinct keys in the random traffic; larger than the table so it can fill.
	localparam int POOL_SIZE = 96;
	// Length of the long output hold, and the watchdog limit on cycles without any transfer.
	localparam int HOLD_CYCLES = 600;
	localparam int STALL_LIMIT = 4000;

	// One expected result of a table operation.
	typedef struct packed {
		logic [skct_pkg::CNT_W-1:0]    key_count;
		logic [skct_pkg::CNT_W-1:0]    total_count;
		logic [skct_pkg::STATUS_W-1:0] status;
	} count_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	logic [skct_pkg::KIND_W-1:0]   kind;
	logic [skct_pkg::KEY_W-1:0]    key;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [skct_pkg::CNT_W-1:0]    key_count;
	logic [skct_pkg::CNT_W-1:0]    total_count;
	logic [skct_pkg::STATUS_W-1:0] status;

	// Our own copy of the table contents, updated at each request transfer.
	logic [skct_pkg::KEY_W-1:0] tally_key [CAPACITY];
	logic [skct_pkg::CNT_W-1:0] tally_cnt [CAPACITY];
	logic                       tally_used [CAPACITY];
	logic [skct_pkg::CNT_W-1:0] tally_total;

	// Results that have been predicted but not yet seen at the output, oldest first.
	count_result_t pending_results [$];

	int  error_count = 0;
	int  ops_sent = 0;
	int  results_checked = 0;
	int  absent_seen = 0;
	int  full_seen = 0;
	int  hold_events = 0;
	int  idle_cycles = 0;
	// When calm is set neither side idles; hold_request asks the receiver for one long hold.
	bit  calm = 1'b0;
	bit  hold_request = 1'b0;

	sparse_key_count_table #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.key(key),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.key_count(key_count),
		.total_count(total_count),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one operation to the table copy and returns the result the block must give.
	// The lowest-numbered matching slot wins and a new key takes the lowest free slot.
	// Counts and the total stick at their maximum; a decrement never takes the total below zero.
	function automatic count_result_t predict_table_op(
			input logic [skct_pkg::KIND_W-1:0] op_kind,
			input logic [skct_pkg::KEY_W-1:0] op_key);
		count_result_t r;
		int hit;
		int free_slot;
		r.key_count = '0;
		r.status = skct_pkg::STATUS_OK;
		hit = -1;
		free_slot = -1;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (tally_used[i] && tally_key[i] == op_key)
				hit = i;
			if (!tally_used[i])
				free_slot = i;
		end
		case (op_kind)
			skct_pkg::KIND_INC: begin
				if (hit >= 0) begin
					if (tally_cnt[hit] != skct_pkg::CNT_MAX) begin
						tally_cnt[hit] = tally_cnt[hit] + 1'b1;
						if (tally_total != skct_pkg::CNT_MAX)
							tally_total = tally_total + 1'b1;
					end
					r.key_count = tally_cnt[hit];
				end else if (free_slot >= 0) begin
					tally_key[free_slot] = op_key;
					tally_cnt[free_slot] = 1;
					tally_used[free_slot] = 1'b1;
					if (tally_total != skct_pkg::CNT_MAX)
						tally_total = tally_total + 1'b1;
					r.key_count = 1;
				end else begin
					r.status = skct_pkg::STATUS_FULL;
				end
			end
			skct_pkg::KIND_DEC: begin
				if (hit >= 0) begin
					if (tally_cnt[hit] <= 1) begin
						tally_cnt[hit] = '0;
						tally_used[hit] = 1'b0;
					end else begin
						tally_cnt[hit] = tally_cnt[hit] - 1'b1;
					end
					r.key_count = tally_cnt[hit];
					if (tally_total != '0)
						tally_total = tally_total - 1'b1;
				end else begin
					r.status = skct_pkg::STATUS_ABSENT;
				end
			end
			default: begin
				// Query and the unused code only read.
				if (hit >= 0)
					r.key_count = tally_cnt[hit];
			end
		endcase
		r.total_count = tally_total;
		return r;
	endfunction

	function automatic int slots_in_use();
		int n;
		n = 0;
		for (int i = 0; i < CAPACITY; i++)
			if (tally_used[i])
				n++;
		return n;
	endfunction

	task automatic report_mismatch(input string what, input logic [skct_pkg::CNT_W-1:0] got,
			input logic [skct_pkg::CNT_W-1:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		error_count++;
	endtask

	// Sends one operation. It is called at a rising edge and returns at the edge of the
	// transfer, where the expected result is queued. A random idle gap may come first.
	task automatic send_table_op(input logic [skct_pkg::KIND_W-1:0] op_kind,
			input logic [skct_pkg::KEY_W-1:0] op_key);
		if (!calm && $urandom_range(99) < 10) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= op_kind;
		key <= op_key;
		// Values read right after the edge are the ones the block sampled at it.
		do
			@(posedge clk);
		while (req_stall);
		pending_results.push_back(predict_table_op(op_kind, op_key));
		ops_sent++;
	endtask

	// Stops offering requests until every predicted result has come out.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Field extremes, every operation code, freeing a slot and the absent-key decrement.
	task automatic test_directed_ops();
		send_table_op(skct_pkg::KIND_INC, '0);
		send_table_op(skct_pkg::KIND_INC, '0);
		send_table_op(skct_pkg::KIND_INC, KEY_TOP);
		send_table_op(skct_pkg::KIND_QRY, '0);
		send_table_op(skct_pkg::KIND_QRY, KEY_TOP);
		send_table_op(KIND_UNUSED, '0);
		send_table_op(skct_pkg::KIND_DEC, '0);
		// Count goes from one to zero, so the slot is released.
		send_table_op(skct_pkg::KIND_DEC, '0);
		send_table_op(skct_pkg::KIND_DEC, '0);
		send_table_op(skct_pkg::KIND_QRY, '0);
		send_table_op(skct_pkg::KIND_INC, 31'h2AAA_AAAA);
		send_table_op(skct_pkg::KIND_INC, 31'h5555_5555);
		send_table_op(skct_pkg::KIND_DEC, KEY_TOP);
		send_table_op(skct_pkg::KIND_QRY, KEY_TOP);
		send_table_op(KIND_UNUSED, 31'h1234_5678);
		send_table_op(skct_pkg::KIND_DEC, 31'h1234_5678);
		send_table_op(skct_pkg::KIND_INC, KEY_TOP);
		send_table_op(skct_pkg::KIND_INC, '0);
		send_table_op(skct_pkg::KIND_QRY, 31'h5555_5555);
		wait_for_results();
	endtask

	// Fills every slot, then checks that new keys are refused while existing ones still count,
	// and that a freed slot is reused.
	task automatic test_fill_to_capacity();
		logic [31:0] raw;
		logic [skct_pkg::KEY_W-1:0] last_key;
		while (slots_in_use() < CAPACITY) begin
			raw = $urandom;
			send_table_op(skct_pkg::KIND_INC, raw[skct_pkg::KEY_W-1:0]);
		end
		repeat (3) begin
			raw = $urandom;
			send_table_op(skct_pkg::KIND_INC, raw[skct_pkg::KEY_W-1:0]);
		end
		raw = $urandom;
		send_table_op(skct_pkg::KIND_DEC, raw[skct_pkg::KEY_W-1:0]);
		send_table_op(skct_pkg::KIND_QRY, raw[skct_pkg::KEY_W-1:0]);
		send_table_op(skct_pkg::KIND_INC, tally_key[CAPACITY / 2]);
		last_key = tally_key[CAPACITY - 1];
		while (tally_used[CAPACITY - 1] && tally_key[CAPACITY - 1] == last_key)
			send_table_op(skct_pkg::KIND_DEC, last_key);
		raw = $urandom;
		send_table_op(skct_pkg::KIND_INC, raw[skct_pkg::KEY_W-1:0]);
		send_table_op(skct_pkg::KIND_INC, raw[skct_pkg::KEY_W-1:0]);
		raw = $urandom;
		send_table_op(skct_pkg::KIND_INC, raw[skct_pkg::KEY_W-1:0]);
		wait_for_results();
	endtask

	// Random operations over a key pool larger than the table. Stretches that favor increments
	// fill the table; stretches that favor decrements drain it. A few keys are fully random
	// and almost never present. One stretch runs with no idling on either side.
	task automatic test_random_traffic(input int n_items);
		logic [skct_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
		logic [skct_pkg::KIND_W-1:0] op_kind;
		logic [skct_pkg::KEY_W-1:0] op_key;
		logic [31:0] raw;
		int inc_weight;
		int roll;
		for (int i = 0; i < POOL_SIZE; i++) begin
			raw = $urandom;
			key_pool[i] = raw[skct_pkg::KEY_W-1:0];
		end
		key_pool[0] = '0;
		key_pool[1] = KEY_TOP;
		inc_weight = 60;
		for (int n = 0; n < n_items; n++) begin
			if (n % 300 == 0)
				inc_weight = ((n / 300) % 2 == 0) ? 60 : 30;
			calm = (n >= 600 && n < 900);
			// Now and then the sender waits for the block to empty completely.
			if (n % 500 == 499)
				wait_for_results();
			roll = $urandom_range(99);
			if (roll < inc_weight)
				op_kind = skct_pkg::KIND_INC;
			else if (roll < 90)
				op_kind = skct_pkg::KIND_DEC;
			else if (roll < 97)
				op_kind = skct_pkg::KIND_QRY;
			else
				op_kind = KIND_UNUSED;
			if ($urandom_range(9) == 0) begin
				raw = $urandom;
				op_key = raw[skct_pkg::KEY_W-1:0];
			end else begin
				op_key = key_pool[$urandom_range(POOL_SIZE - 1)];
			end
			send_table_op(op_kind, op_key);
		end
		calm = 1'b0;
		wait_for_results();
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so the block
	// backs up and has to stall its input.
	task automatic test_output_hold();
		logic [31:0] raw;
		hold_request = 1'b1;
		repeat (30) begin
			raw = $urandom;
			send_table_op(raw[1:0], {27'd0, raw[6:3]});
		end
		wait_for_results();
	endtask

	// Receiver: random stall about one cycle in ten, none while calm, and one long
	// hold on request that this process counts out itself.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_events++;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				rsp_stall <= !calm && $urandom_range(99) < 10;
			end
		end
	end

	// Result checker: every output transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		count_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request waiting", key_count, '0);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.status == skct_pkg::STATUS_ABSENT)
					absent_seen++;
				if (want.status == skct_pkg::STATUS_FULL)
					full_seen++;
				if (key_count !== want.key_count)
					report_mismatch("key_count", key_count, want.key_count);
				if (total_count !== want.total_count)
					report_mismatch("total_count", total_count, want.total_count);
				if (status !== want.status)
					report_mismatch("status", {30'd0, status}, {30'd0, want.status});
			end
		end
	end

	// Watchdog: too long without a transfer on either channel ends the run.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles at %0t", STALL_LIMIT, $time);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = skct_pkg::KIND_QRY;
		key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tally_key[i] = '0;
			tally_cnt[i] = '0;
			tally_used[i] = 1'b0;
		end
		tally_total = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_fill_to_capacity();
		test_random_traffic(1850);
		test_output_hold();

		// Let any late or stray result show up before the verdict.
		wait_for_results();
		repeat (CAPACITY + 16) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", pending_results.size(), '0);

		$display("Run covered %0d requests and %0d results, with %0d absent-key decrements",
			ops_sent, results_checked, absent_seen);
		$display("and %0d inserts refused by a full table; long output holds: %0d",
			full_seen, hold_events);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
